// File: rtl/core/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Types and constants shared by the character LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_SETPOS = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_INIT = 2'd3
    } req_kind_t;

    // request transaction on the input side
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       register_select;
        logic [4:0] column;
        logic [1:0] row;
    } req_item_t;

    // nibble transfer on the output side
    typedef struct packed {
        logic        rs_level;
        logic [3:0]  nibble;
        logic [13:0] pre_wait_us;
        logic [11:0] post_wait_us;
        logic        last;
    } xfer_item_t;

    // decoded command held in the queue between front and back
    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] cmd_byte;
        logic       rs;
    } cmd_t;

    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    localparam logic [5:0] ROW_WRAP_COLS = 6'd20;

    localparam logic [13:0] WAIT_POWERUP_US = 14'd15000;
    localparam logic [11:0] WAIT_WAKE1_US = 12'd4000;
    localparam logic [11:0] WAIT_WAKE2_US = 12'd100;
    localparam logic [11:0] WAIT_CMD_US = 12'd1000;
    localparam logic [11:0] WAIT_CLEAR_US = 12'd1500;

endpackage

// File: rtl/core/clnw_front.sv
// ----------------------------------------------------------------------------
// clnw_front
// Accepts requests, tracks the held RS level and decodes each request into
// one command for the queue.
// ----------------------------------------------------------------------------
module clnw_front
    import clnw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    input  logic      q_full,
    output logic      q_push,
    output cmd_t      q_cmd
);

    logic       rs_held_reg;
    logic       rs_held_next;
    logic [5:0] col_eff;
    logic       row_eff;
    req_kind_t  kind;

    assign req_stall = q_full;
    assign q_push = req_valid && !q_full;
    assign kind = req_kind_t'(req.req_type);

    // rows 2 and 3 continue rows 0 and 1 twenty columns on
    assign col_eff = req.row[1] ? ({1'b0, req.column} + ROW_WRAP_COLS) : {1'b0, req.column};
    assign row_eff = req.row[0];

    always_comb
    begin
        q_cmd.kind = kind;
        q_cmd.cmd_byte = CMD_CLEAR;
        q_cmd.rs = 1'b0;
        unique case (kind)
            REQ_WRITE:
            begin
                q_cmd.cmd_byte = req.data_byte;
                q_cmd.rs = req.register_select;
            end
            REQ_SETPOS:
            begin
                // col_eff stays below 64, so 0x40*row + col is a plain concat
                q_cmd.cmd_byte = {1'b1, row_eff, col_eff};
            end
            REQ_CLEAR:
            begin
                q_cmd.cmd_byte = CMD_CLEAR;
            end
            REQ_INIT:
            begin
                q_cmd.rs = rs_held_reg;
            end
            default:
            begin
                q_cmd.cmd_byte = CMD_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        rs_held_next = rs_held_reg;
        if (q_push)
        begin
            rs_held_next = (kind == REQ_WRITE) ? req.register_select : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_held_reg <= 1'b0;
        end
        else
        begin
            rs_held_reg <= rs_held_next;
        end
    end

endmodule

// File: rtl/core/clnw_queue.sv
// ----------------------------------------------------------------------------
// clnw_queue
// Small command FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module clnw_queue
    import clnw_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/clnw_back.sv
// ----------------------------------------------------------------------------
// clnw_back
// Sequencer that turns each queued command into its nibble transfers and
// drives the registered output.
// ----------------------------------------------------------------------------
module clnw_back
    import clnw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       xfer_valid,
    input  logic       xfer_stall,
    output xfer_item_t xfer
);

    localparam logic [3:0] STEP_LAST_BYTE = 4'd1;
    localparam logic [3:0] STEP_LAST_INIT = 4'd11;

    logic       active_reg, active_next;
    logic [3:0] step_reg, step_next;
    cmd_t       cmd_reg, cmd_next;
    logic       xfer_valid_reg, xfer_valid_next;
    xfer_item_t xfer_reg;
    cmd_t       cur;
    logic       have_work;
    logic       load;
    logic       step_last;
    xfer_item_t cur_xfer;

    function automatic xfer_item_t xfer_for(cmd_t c, logic [3:0] step);
        xfer_item_t x;
        logic [7:0] b;
        x.rs_level = c.rs;
        x.nibble = step[0] ? c.cmd_byte[3:0] : c.cmd_byte[7:4];
        x.pre_wait_us = '0;
        x.post_wait_us = '0;
        x.last = step[0];
        if (c.kind == REQ_INIT)
        begin
            x.last = (step == STEP_LAST_INIT);
            // wake-up nibbles first, then four full commands at RS low
            case (step)
                4'd0:
                begin
                    x.nibble = NIB_WAKE;
                    x.pre_wait_us = WAIT_POWERUP_US;
                    x.post_wait_us = WAIT_WAKE1_US;
                end
                4'd1:
                begin
                    x.nibble = NIB_WAKE;
                    x.post_wait_us = WAIT_WAKE2_US;
                end
                4'd2:
                begin
                    x.nibble = NIB_WAKE;
                    x.post_wait_us = WAIT_CMD_US;
                end
                4'd3:
                begin
                    x.nibble = NIB_4BIT;
                    x.post_wait_us = WAIT_CMD_US;
                end
                default:
                begin
                    case (step[3:1])
                        3'd2:    b = CMD_FUNC_SET;
                        3'd3:    b = CMD_DISP_ON;
                        3'd4:    b = CMD_ENTRY_MODE;
                        default: b = CMD_CLEAR;
                    endcase
                    x.rs_level = 1'b0;
                    x.nibble = step[0] ? b[3:0] : b[7:4];
                    if (step[0])
                    begin
                        x.post_wait_us = (step == STEP_LAST_INIT) ? WAIT_CLEAR_US : WAIT_CMD_US;
                    end
                end
            endcase
        end
        else if (c.kind == REQ_CLEAR && step[0])
        begin
            x.post_wait_us = WAIT_CLEAR_US;
        end
        return x;
    endfunction

    assign cur = active_reg ? cmd_reg : q_head;
    assign have_work = active_reg || !q_empty;
    assign load = have_work && (!xfer_valid_reg || !xfer_stall);
    assign q_pop = load && !active_reg;
    assign step_last = (cur.kind == REQ_INIT) ? (step_reg == STEP_LAST_INIT)
                                              : (step_reg == STEP_LAST_BYTE);
    assign cur_xfer = xfer_for(cur, step_reg);

    assign xfer_valid = xfer_valid_reg;
    assign xfer = xfer_reg;

    always_comb
    begin
        active_next = active_reg;
        step_next = step_reg;
        cmd_next = cmd_reg;
        xfer_valid_next = xfer_valid_reg;
        if (xfer_valid_reg && !xfer_stall)
        begin
            xfer_valid_next = 1'b0;
        end
        if (load)
        begin
            xfer_valid_next = 1'b1;
            cmd_next = cur;
            if (step_last)
            begin
                active_next = 1'b0;
                step_next = '0;
            end
            else
            begin
                active_next = 1'b1;
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (load)
        begin
            xfer_reg <= cur_xfer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg <= '0;
            xfer_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg <= step_next;
            xfer_valid_reg <= xfer_valid_next;
        end
    end

endmodule

// File: rtl/core/char_lcd_nibble_writer.sv
// The first transfer of a request is registered in the command queue, then in the output register.
// The back sequencer issues one transfer per cycle while the output is not stalled; a request
// gives 2 transfers (write, set position, clear) or 12 transfers (initialise).
// The command queue of QUEUE_DEPTH entries lets requests be taken while transfers stall.
// Reset: asynchronous, active low; queue empty, output invalid, held RS level low.
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Top level: 4-bit character LCD nibble transfer generator.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer
    import clnw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_item_t  req,
    output logic       xfer_valid,
    input  logic       xfer_stall,
    output xfer_item_t xfer
);

    logic q_push;
    cmd_t q_cmd;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_head;

    clnw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    clnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    clnw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .xfer_valid (xfer_valid),
        .xfer_stall (xfer_stall),
        .xfer       (xfer)
    );

endmodule

// File: rtl/core/clnw_checker.sv
// ----------------------------------------------------------------------------
// clnw_checker
// Port-level checks on the nibble writer's transfer stream.
// ----------------------------------------------------------------------------
module clnw_checker
    import clnw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       xfer_valid,
    input logic       xfer_stall,
    input xfer_item_t xfer
);

    // stalled transfer holds
    a_xfer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && xfer_stall |=> xfer_valid && $stable(xfer))
        else $error("stalled transfer changed");

    // only the first power-up nibble carries a pre wait
    a_pre_wait: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && (xfer.pre_wait_us != '0) |->
            (xfer.nibble == NIB_WAKE) && !xfer.last && (xfer.post_wait_us == WAIT_WAKE1_US))
        else $error("unexpected pre wait");

    // clear wait only on the final low nibble of a clear command
    a_clear_wait: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && (xfer.post_wait_us == WAIT_CLEAR_US) |->
            xfer.last && (xfer.nibble == CMD_CLEAR[3:0]) && !xfer.rs_level)
        else $error("clear wait on wrong transfer");

    // the 100 us wake wait directly follows the power-up nibble
    a_wake_order: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && !xfer_stall && (xfer.pre_wait_us == WAIT_POWERUP_US) |=>
            !xfer_valid || (xfer.post_wait_us == WAIT_WAKE2_US))
        else $error("power-up sequence out of order");

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .xfer_valid (xfer_valid),
    .xfer_stall (xfer_stall),
    .xfer       (xfer)
);

// File: test/tb_char_lcd_nibble_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer
// Self-checking bench for the 4-bit character LCD nibble writer. A directed
// table covers field extremes, row folding, out-of-range columns and the
// held RS level on power-up, then random requests run under three idle
// patterns. Every transfer is checked field by field against the predictor or a directed row's own answer.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_writer
    import clnw_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 33;
    localparam int DRAIN_CYCLES = 30;
    localparam int DIR_ROWS = 23;
    localparam int REQ_W = $bits(req_item_t);

    typedef struct {
        req_item_t  rq;
        bit         typed;      // expected byte given in the row
        logic [7:0] exp_byte;
        logic       exp_rs;
        logic [11:0] exp_post;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_item_t  req;
    logic       xfer_valid;
    logic       xfer_stall;
    xfer_item_t xfer;

    xfer_item_t expected_xfers[$];
    xfer_item_t scratch_xfers[$];
    logic       rs_held;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         error_count;
    int         reqs_sent;
    int         inits_sent;
    int         xfers_checked;
    int         idle_cycles;

    // req fields: req_type, data_byte, register_select, column, row
    dir_row_t dir_table [DIR_ROWS] = '{
        '{'{REQ_INIT,   8'h00, 1'b0, 5'd0,  2'd0}, 1'b0, 8'h00, 1'b0, 12'd0},
        '{'{REQ_WRITE,  8'h00, 1'b0, 5'd0,  2'd0}, 1'b1, 8'h00, 1'b0, 12'd0},
        '{'{REQ_WRITE,  8'hFF, 1'b1, 5'd0,  2'd0}, 1'b1, 8'hFF, 1'b1, 12'd0},
        '{'{REQ_INIT,   8'h00, 1'b0, 5'd0,  2'd0}, 1'b0, 8'h00, 1'b0, 12'd0},
        '{'{REQ_CLEAR,  8'h00, 1'b0, 5'd0,  2'd0}, 1'b1, 8'h01, 1'b0, 12'd1500},
        '{'{REQ_SETPOS, 8'h00, 1'b0, 5'd0,  2'd0}, 1'b1, 8'h80, 1'b0, 12'd0},
        '{'{REQ_SETPOS, 8'h00, 1'b0, 5'd19, 2'd1}, 1'b1, 8'hD3, 1'b0, 12'd0},
        '{'{REQ_SETPOS, 8'h00, 1'b0, 5'd0,  2'd2}, 1'b1, 8'h94, 1'b0, 12'd0},
        '{'{REQ_SETPOS, 8'h00, 1'b0, 5'd19, 2'd3}, 1'b1, 8'hE7, 1'b0, 12'd0},
        '{'{REQ_SETPOS, 8'h00, 1'b0, 5'd31, 2'd0}, 1'b1, 8'h9F, 1'b0, 12'd0},
        '{'{REQ_SETPOS, 8'h00, 1'b0, 5'd31, 2'd1}, 1'b1, 8'hDF, 1'b0, 12'd0},
        '{'{REQ_SETPOS, 8'h00, 1'b0, 5'd31, 2'd2}, 1'b1, 8'hB3, 1'b0, 12'd0},
        '{'{REQ_SETPOS, 8'hFF, 1'b1, 5'd31, 2'd3}, 1'b1, 8'hF3, 1'b0, 12'd0},
        '{'{REQ_WRITE,  8'hA5, 1'b1, 5'd31, 2'd3}, 1'b1, 8'hA5, 1'b1, 12'd0},
        '{'{REQ_INIT,   8'hFF, 1'b1, 5'd31, 2'd3}, 1'b0, 8'h00, 1'b0, 12'd0},
        '{'{REQ_WRITE,  8'h5A, 1'b0, 5'd21, 2'd2}, 1'b1, 8'h5A, 1'b0, 12'd0},
        '{'{REQ_WRITE,  8'h3C, 1'b1, 5'd0,  2'd0}, 1'b1, 8'h3C, 1'b1, 12'd0},
        '{'{REQ_SETPOS, 8'h00, 1'b1, 5'd5,  2'd0}, 1'b1, 8'h85, 1'b0, 12'd0},
        '{'{REQ_INIT,   8'h00, 1'b0, 5'd0,  2'd0}, 1'b0, 8'h00, 1'b0, 12'd0},
        '{'{REQ_WRITE,  8'h81, 1'b1, 5'd10, 2'd1}, 1'b1, 8'h81, 1'b1, 12'd0},
        '{'{REQ_CLEAR,  8'hFF, 1'b1, 5'd31, 2'd3}, 1'b1, 8'h01, 1'b0, 12'd1500},
        '{'{REQ_INIT,   8'h00, 1'b0, 5'd0,  2'd0}, 1'b0, 8'h00, 1'b0, 12'd0},
        '{'{REQ_INIT,   8'hC3, 1'b1, 5'd16, 2'd2}, 1'b0, 8'h00, 1'b0, 12'd0}
    };

    char_lcd_nibble_writer uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .xfer_valid (xfer_valid),
        .xfer_stall (xfer_stall),
        .xfer       (xfer)
    );

    always
    begin
        #1 clk = 1'b0;
        #1 clk = 1'b1;
    end

    function automatic void add_nibble(ref xfer_item_t dst[$], input logic rs,
                                       input logic [3:0] nib, input logic [13:0] pre,
                                       input logic [11:0] post, input logic fin);
        xfer_item_t t;
        t.rs_level = rs;
        t.nibble = nib;
        t.pre_wait_us = pre;
        t.post_wait_us = post;
        t.last = fin;
        dst.push_back(t);
    endfunction

    // high nibble first, post wait only on the low nibble
    function automatic void add_byte(ref xfer_item_t dst[$], input logic [7:0] b,
                                     input logic rs, input logic [11:0] post,
                                     input logic fin);
        add_nibble(dst, rs, b[7:4], 14'd0, 12'd0, 1'b0);
        add_nibble(dst, rs, b[3:0], 14'd0, post, fin);
    endfunction

    task automatic predict_lcd_xfers(input req_item_t r, ref xfer_item_t dst[$]);
        logic [1:0] line_sel;
        logic [5:0] col_eff;
        logic [7:0] ddram_cmd;
        case (r.req_type)
            REQ_WRITE:
            begin
                add_byte(dst, r.data_byte, r.register_select, 12'd0, 1'b1);
                rs_held = r.register_select;
            end
            REQ_SETPOS:
            begin
                // rows 2 and 3 continue rows 0 and 1 from column 20 on
                line_sel = r.row;
                col_eff = {1'b0, r.column};
                if (r.row[1])
                begin
                    line_sel = {1'b0, r.row[0]};
                    col_eff = col_eff + 6'd20;
                end
                ddram_cmd = ({line_sel, 6'b0} + {2'b0, col_eff}) | 8'h80;
                add_byte(dst, ddram_cmd, 1'b0, 12'd0, 1'b1);
                rs_held = 1'b0;
            end
            REQ_CLEAR:
            begin
                add_byte(dst, 8'h01, 1'b0, 12'd1500, 1'b1);
                rs_held = 1'b0;
            end
            default:
            begin
                // wake-up nibbles go out at whatever RS level was left behind
                add_nibble(dst, rs_held, 4'h3, 14'd15000, 12'd4000, 1'b0);
                add_nibble(dst, rs_held, 4'h3, 14'd0, 12'd100, 1'b0);
                add_nibble(dst, rs_held, 4'h3, 14'd0, 12'd1000, 1'b0);
                add_nibble(dst, rs_held, 4'h2, 14'd0, 12'd1000, 1'b0);
                add_byte(dst, 8'h28, 1'b0, 12'd1000, 1'b0);
                add_byte(dst, 8'h0C, 1'b0, 12'd1000, 1'b0);
                add_byte(dst, 8'h06, 1'b0, 12'd1000, 1'b0);
                add_byte(dst, 8'h01, 1'b0, 12'd1500, 1'b1);
                rs_held = 1'b0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // returns at the rising edge where the request transaction is taken
    task automatic send_req(input req_item_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        reqs_sent++;
        if (r.req_type == REQ_INIT)
            inits_sent++;
    endtask

    task automatic issue_req(input req_item_t r);
        send_req(r);
        predict_lcd_xfers(r, expected_xfers);
    endtask

    function automatic req_item_t random_req();
        req_item_t r;
        int pick;
        r = req_item_t'(REQ_W'($urandom));
        pick = $urandom_range(99);
        if (pick < 40)
            r.req_type = REQ_WRITE;
        else if (pick < 70)
            r.req_type = REQ_SETPOS;
        else if (pick < 85)
            r.req_type = REQ_CLEAR;
        else
            r.req_type = REQ_INIT;
        if ($urandom_range(99) < 85)
            r.column = 5'($urandom_range(19));
        return r;
    endfunction

    always @(negedge clk)
    begin
        xfer_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        xfer_item_t want;
        if (rst_n && xfer_valid && !xfer_stall)
        begin
            xfers_checked++;
            if (expected_xfers.size() == 0)
            begin
                report_mismatch("transfer with none pending, nibble", int'(xfer.nibble), -1);
            end
            else
            begin
                want = expected_xfers.pop_front();
                if (xfer.rs_level !== want.rs_level)
                    report_mismatch("rs_level", int'(xfer.rs_level), int'(want.rs_level));
                if (xfer.nibble !== want.nibble)
                    report_mismatch("nibble", int'(xfer.nibble), int'(want.nibble));
                if (xfer.pre_wait_us !== want.pre_wait_us)
                    report_mismatch("pre_wait_us", int'(xfer.pre_wait_us),
                                    int'(want.pre_wait_us));
                if (xfer.post_wait_us !== want.post_wait_us)
                    report_mismatch("post_wait_us", int'(xfer.post_wait_us),
                                    int'(want.post_wait_us));
                if (xfer.last !== want.last)
                    report_mismatch("last", int'(xfer.last), int'(want.last));
            end
        end
    end

    // ends a hung run: cycles with neither transaction side moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (xfer_valid && !xfer_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d transfers pending", expected_xfers.size());
                $display("char_lcd_nibble_writer test failed");
                $finish;
            end
        end
    end

    initial
    begin
        req_item_t r;
        int phase;
        int phase_count;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rs_held = 1'b0;
        send_idle_pct = 23;
        recv_stall_pct = 57;
        error_count = 0;
        reqs_sent = 0;
        inits_sent = 0;
        xfers_checked = 0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_req(dir_table[i].rq);
            if (dir_table[i].typed)
            begin
                // keep the predictor state in step, use the row's own answer
                scratch_xfers.delete();
                predict_lcd_xfers(dir_table[i].rq, scratch_xfers);
                add_byte(expected_xfers, dir_table[i].exp_byte, dir_table[i].exp_rs,
                         dir_table[i].exp_post, 1'b1);
            end
            else
            begin
                predict_lcd_xfers(dir_table[i].rq, expected_xfers);
            end
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 57 : 0;
            recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 23 : 0;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // data write left RS high, then power-up inherits it
                    r = random_req();
                    r.req_type = REQ_WRITE;
                    r.register_select = 1'b1;
                    issue_req(r);
                    r = random_req();
                    r.req_type = REQ_INIT;
                    issue_req(r);
                    phase_count += 2;
                end
                else
                begin
                    issue_req(random_req());
                    phase_count++;
                end
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_xfers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests (%0d power-up runs) sent, %0d transfers checked",
                 reqs_sent, inits_sent, xfers_checked);
        $display("idle patterns: sender-heavy, receiver-heavy, back to back");
        if (error_count == 0)
            $display("char_lcd_nibble_writer test passed");
        else
            $display("char_lcd_nibble_writer test failed");
        $finish;
    end

endmodule
